// ----- rtl/core/ahoc_pkg.sv -----
// ----------------------------------------------------------------------------
// ahoc_pkg: shared types and constants of the Aho-Corasick matcher
// Transaction payload structs, operation codes, sequencer states, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package ahoc_pkg;

    // Default sizing
    localparam int MAX_NODES_DEF     = 4096;
    localparam int ALPHABET_SIZE_DEF = 26;

    // Counts saturate at the top of the 12-bit field
    localparam int          COUNT_W   = 12;
    localparam logic [11:0] COUNT_MAX = 12'hFFF;

    // Operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_BUILD  = 2'd2;
    localparam logic [1:0] OP_SCAN   = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] letter;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [11:0] match_count;
        logic        overflow;
    } result_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_ZERO,
        S_INS_END,
        S_INS_CNT,
        S_B0_RD,
        S_B0_CHK,
        S_B_POP,
        S_B_POPD,
        S_B_KID_RD,
        S_B_KID,
        S_B_FU,
        S_B_SET,
        S_F_RD,
        S_F_CHK,
        S_F_FL,
        S_S_START,
        S_S_WALK,
        S_S_WCHK,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/aho_corasick_matcher.sv -----
// ----------------------------------------------------------------------------
// aho_corasick_matcher: dictionary matcher, top level
// Builds a trie with failure links and counts dictionary patterns in text.
// ----------------------------------------------------------------------------
//  channel | signals                              | payload
//  --------+--------------------------------------+---------------------------
//  item    | item_valid, item_ready, item         | op, letter, last
//  result  | result_valid, result_ready, result   | match_count, overflow
//
//  Each memory access costs one state; one transaction at a time.
//  Clear sweeps the root row. Insert zeroes the letter row of each new node.
//  Build visits every letter slot of each node and probes failure links.
//  Scan probes failure links, then walks the newly consumed nodes.
//  After reset the root row sweep holds item_ready low.
//  A pending result stalls only a scan ending its text, in the emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module aho_corasick_matcher #(
    parameter int MAX_NODES     = ahoc_pkg::MAX_NODES_DEF,
    parameter int ALPHABET_SIZE = ahoc_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire ahoc_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output ahoc_pkg::result_t      result
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES * ALPHABET_SIZE);

    logic          child_we, child_re;
    logic [CW-1:0] child_addr;
    logic [NW-1:0] child_wdata, child_rdata;
    logic          fail_we, fail_re;
    logic [NW-1:0] fail_waddr, fail_wdata, fail_raddr, fail_rdata;
    logic          cnt_we, cnt_re;
    logic [NW-1:0] cnt_waddr, cnt_raddr;
    logic [11:0]   cnt_wdata, cnt_rdata;
    logic          cons_we, cons_re, cons_wdata, cons_rdata;
    logic [NW-1:0] cons_waddr, cons_raddr;
    logic          queue_we, queue_re;
    logic [NW-1:0] queue_waddr, queue_wdata, queue_raddr, queue_rdata;

    ahoc_ctrl #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .child_we     (child_we),
        .child_re     (child_re),
        .child_addr   (child_addr),
        .child_wdata  (child_wdata),
        .child_rdata  (child_rdata),
        .fail_we      (fail_we),
        .fail_waddr   (fail_waddr),
        .fail_wdata   (fail_wdata),
        .fail_re      (fail_re),
        .fail_raddr   (fail_raddr),
        .fail_rdata   (fail_rdata),
        .cnt_we       (cnt_we),
        .cnt_waddr    (cnt_waddr),
        .cnt_wdata    (cnt_wdata),
        .cnt_re       (cnt_re),
        .cnt_raddr    (cnt_raddr),
        .cnt_rdata    (cnt_rdata),
        .cons_we      (cons_we),
        .cons_waddr   (cons_waddr),
        .cons_wdata   (cons_wdata),
        .cons_re      (cons_re),
        .cons_raddr   (cons_raddr),
        .cons_rdata   (cons_rdata),
        .queue_we     (queue_we),
        .queue_waddr  (queue_waddr),
        .queue_wdata  (queue_wdata),
        .queue_re     (queue_re),
        .queue_raddr  (queue_raddr),
        .queue_rdata  (queue_rdata)
    );

    // Trie children, one row of letters per node
    ahoc_ram #(.DEPTH(MAX_NODES * ALPHABET_SIZE), .WIDTH(NW)) u_child (
        .clk (clk), .we (child_we), .waddr (child_addr), .wdata (child_wdata),
        .re (child_re), .raddr (child_addr), .rdata (child_rdata)
    );

    ahoc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_fail (
        .clk (clk), .we (fail_we), .waddr (fail_waddr), .wdata (fail_wdata),
        .re (fail_re), .raddr (fail_raddr), .rdata (fail_rdata)
    );

    ahoc_ram #(.DEPTH(MAX_NODES), .WIDTH(ahoc_pkg::COUNT_W)) u_cnt (
        .clk (clk), .we (cnt_we), .waddr (cnt_waddr), .wdata (cnt_wdata),
        .re (cnt_re), .raddr (cnt_raddr), .rdata (cnt_rdata)
    );

    ahoc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_cons (
        .clk (clk), .we (cons_we), .waddr (cons_waddr), .wdata (cons_wdata),
        .re (cons_re), .raddr (cons_raddr), .rdata (cons_rdata)
    );

    ahoc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_queue (
        .clk (clk), .we (queue_we), .waddr (queue_waddr), .wdata (queue_wdata),
        .re (queue_re), .raddr (queue_raddr), .rdata (queue_rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ahoc_ram.sv -----
// ----------------------------------------------------------------------------
// ahoc_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ahoc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ahoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ahoc_ctrl: matcher sequencer
// Drives trie, link, count, consumed and queue memories, one memory step per
// state; trie rows are addressed through one shared node-times-alphabet unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ahoc_ctrl #(
    parameter int MAX_NODES     = ahoc_pkg::MAX_NODES_DEF,
    parameter int ALPHABET_SIZE = ahoc_pkg::ALPHABET_SIZE_DEF,
    localparam int NW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES * ALPHABET_SIZE)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire ahoc_pkg::item_t  item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output ahoc_pkg::result_t     result,
    // trie memory
    output logic                  child_we,
    output logic                  child_re,
    output logic [CW-1:0]         child_addr,
    output logic [NW-1:0]         child_wdata,
    input  wire logic [NW-1:0]    child_rdata,
    // failure links
    output logic                  fail_we,
    output logic [NW-1:0]         fail_waddr,
    output logic [NW-1:0]         fail_wdata,
    output logic                  fail_re,
    output logic [NW-1:0]         fail_raddr,
    input  wire logic [NW-1:0]    fail_rdata,
    // pattern counts
    output logic                  cnt_we,
    output logic [NW-1:0]         cnt_waddr,
    output logic [11:0]           cnt_wdata,
    output logic                  cnt_re,
    output logic [NW-1:0]         cnt_raddr,
    input  wire logic [11:0]      cnt_rdata,
    // consumed marks
    output logic                  cons_we,
    output logic [NW-1:0]         cons_waddr,
    output logic                  cons_wdata,
    output logic                  cons_re,
    output logic [NW-1:0]         cons_raddr,
    input  wire logic             cons_rdata,
    // breadth-first queue
    output logic                  queue_we,
    output logic [NW-1:0]         queue_waddr,
    output logic [NW-1:0]         queue_wdata,
    output logic                  queue_re,
    output logic [NW-1:0]         queue_raddr,
    input  wire logic [NW-1:0]    queue_rdata
);

    localparam int LW = $clog2(ALPHABET_SIZE);
    localparam logic [NW:0]   MAX_N    = (NW+1)'(MAX_NODES);
    localparam logic [LW-1:0] LAST_LTR = LW'(ALPHABET_SIZE - 1);

    ahoc_pkg::state_t state_reg, state_next;

    logic [LW-1:0]   i_reg, i_next;
    logic [LW-1:0]   c_reg, c_next;
    logic [NW:0]     free_reg, free_next;
    logic [NW-1:0]   ins_cur_reg, ins_cur_next;
    logic [NW-1:0]   scan_cur_reg, scan_cur_next;
    logic [11:0]     total_reg, total_next;
    logic            ovf_reg, ovf_next;
    logic            drop_reg, drop_next;
    logic [NW:0]     head_reg, head_next;
    logic [NW:0]     tail_reg, tail_next;
    logic [NW:0]     guard_reg, guard_next;
    logic            last_reg, last_next;
    logic            ret_build_reg, ret_build_next;
    logic            out_valid_reg, out_valid_next;
    logic [NW-1:0]   u_reg, u_next;
    logic [NW-1:0]   v_reg, v_next;
    logic [NW-1:0]   t_reg, t_next;
    logic [NW-1:0]   j_reg, j_next;
    ahoc_pkg::result_t out_reg, out_next;

    logic [NW-1:0]   cm_node;
    logic [LW-1:0]   cm_letter;
    logic            letter_ok;
    logic [12:0]     sum;

    // Shared address unit: node * alphabet + letter
    assign child_addr = CW'(cm_node) * CW'(ALPHABET_SIZE) + CW'(cm_letter);

    assign letter_ok = (32'(item.letter) < 32'(ALPHABET_SIZE));
    assign sum       = {1'b0, total_reg} + {1'b0, cnt_rdata};

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ahoc_pkg::S_CLR;
            i_reg         <= '0;
            free_reg      <= (NW+1)'(1);
            ins_cur_reg   <= '0;
            scan_cur_reg  <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            guard_reg     <= '0;
            last_reg      <= 1'b0;
            ret_build_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            free_reg      <= free_next;
            ins_cur_reg   <= ins_cur_next;
            scan_cur_reg  <= scan_cur_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            drop_reg      <= drop_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            guard_reg     <= guard_next;
            last_reg      <= last_next;
            ret_build_reg <= ret_build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold node pointers and result payload
    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        t_reg   <= t_next;
        j_reg   <= j_next;
        out_reg <= out_next;
    end

    // Sequence one transaction through the memories
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        c_next         = c_reg;
        free_next      = free_reg;
        ins_cur_next   = ins_cur_reg;
        scan_cur_next  = scan_cur_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        drop_next      = drop_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        guard_next     = guard_reg;
        last_next      = last_reg;
        ret_build_next = ret_build_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        t_next         = t_reg;
        j_next         = j_reg;

        item_ready  = 1'b0;
        cm_node     = '0;
        cm_letter   = i_reg;
        child_we    = 1'b0;
        child_re    = 1'b0;
        child_wdata = '0;
        fail_we     = 1'b0;
        fail_waddr  = '0;
        fail_wdata  = '0;
        fail_re     = 1'b0;
        fail_raddr  = '0;
        cnt_we      = 1'b0;
        cnt_waddr   = '0;
        cnt_wdata   = '0;
        cnt_re      = 1'b0;
        cnt_raddr   = '0;
        cons_we     = 1'b0;
        cons_waddr  = '0;
        cons_wdata  = 1'b0;
        cons_re     = 1'b0;
        cons_raddr  = '0;
        queue_we    = 1'b0;
        queue_waddr = '0;
        queue_wdata = '0;
        queue_re    = 1'b0;
        queue_raddr = '0;

        unique case (state_reg)
            // Zero the root's children, one letter a cycle
            ahoc_pkg::S_CLR:
            begin
                child_we = 1'b1;
                i_next   = i_reg + 1'b1;
                if (i_reg == LAST_LTR)
                begin
                    i_next     = '0;
                    state_next = ahoc_pkg::S_IDLE;
                end
            end

            ahoc_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    last_next = item.last;
                    c_next    = LW'(item.letter);
                    unique case (item.op)
                        ahoc_pkg::OP_CLEAR:
                        begin
                            free_next     = (NW+1)'(1);
                            ins_cur_next  = '0;
                            scan_cur_next = '0;
                            total_next    = '0;
                            ovf_next      = 1'b0;
                            drop_next     = 1'b0;
                            i_next        = '0;
                            state_next    = ahoc_pkg::S_CLR;
                        end
                        ahoc_pkg::OP_INSERT:
                        begin
                            if (!drop_reg && letter_ok)
                            begin
                                state_next = ahoc_pkg::S_INS_RD;
                            end
                            else
                            begin
                                state_next = ahoc_pkg::S_INS_END;
                            end
                        end
                        ahoc_pkg::OP_BUILD:
                        begin
                            i_next     = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = ahoc_pkg::S_B0_RD;
                        end
                        ahoc_pkg::OP_SCAN:
                        begin
                            if (letter_ok)
                            begin
                                v_next         = scan_cur_reg;
                                guard_next     = '0;
                                ret_build_next = 1'b0;
                                state_next     = ahoc_pkg::S_F_RD;
                            end
                            else
                            begin
                                j_next     = '0;
                                state_next = ahoc_pkg::S_S_START;
                            end
                        end
                        default:
                        begin
                            state_next = ahoc_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // Look up the child of the insert cursor
            ahoc_pkg::S_INS_RD:
            begin
                child_re   = 1'b1;
                cm_node    = ins_cur_reg;
                cm_letter  = c_reg;
                state_next = ahoc_pkg::S_INS_CHK;
            end

            // Advance, allocate a fresh node, or drop on a full trie
            ahoc_pkg::S_INS_CHK:
            begin
                cm_node   = ins_cur_reg;
                cm_letter = c_reg;
                if (child_rdata != '0)
                begin
                    ins_cur_next = child_rdata;
                    state_next   = ahoc_pkg::S_INS_END;
                end
                else if (free_reg < MAX_N)
                begin
                    child_we     = 1'b1;
                    child_wdata  = free_reg[NW-1:0];
                    fail_we      = 1'b1;
                    fail_waddr   = free_reg[NW-1:0];
                    cnt_we       = 1'b1;
                    cnt_waddr    = free_reg[NW-1:0];
                    cons_we      = 1'b1;
                    cons_waddr   = free_reg[NW-1:0];
                    ins_cur_next = free_reg[NW-1:0];
                    free_next    = free_reg + 1'b1;
                    i_next       = '0;
                    state_next   = ahoc_pkg::S_INS_ZERO;
                end
                else
                begin
                    ovf_next   = 1'b1;
                    drop_next  = 1'b1;
                    state_next = ahoc_pkg::S_INS_END;
                end
            end

            // Zero the new node's children
            ahoc_pkg::S_INS_ZERO:
            begin
                child_we = 1'b1;
                cm_node  = ins_cur_reg;
                i_next   = i_reg + 1'b1;
                if (i_reg == LAST_LTR)
                begin
                    i_next     = '0;
                    state_next = ahoc_pkg::S_INS_END;
                end
            end

            ahoc_pkg::S_INS_END:
            begin
                state_next = ahoc_pkg::S_IDLE;
                if (last_reg)
                begin
                    if (!drop_reg)
                    begin
                        cnt_re     = 1'b1;
                        cnt_raddr  = ins_cur_reg;
                        state_next = ahoc_pkg::S_INS_CNT;
                    end
                    else
                    begin
                        ins_cur_next = '0;
                        drop_next    = 1'b0;
                    end
                end
            end

            // Bump the pattern count, saturating
            ahoc_pkg::S_INS_CNT:
            begin
                cnt_we       = 1'b1;
                cnt_waddr    = ins_cur_reg;
                cnt_wdata    = (cnt_rdata == ahoc_pkg::COUNT_MAX) ? cnt_rdata
                                                                  : cnt_rdata + 1'b1;
                ins_cur_next = '0;
                drop_next    = 1'b0;
                state_next   = ahoc_pkg::S_IDLE;
            end

            // Seed the queue with the root's children
            ahoc_pkg::S_B0_RD:
            begin
                child_re   = 1'b1;
                state_next = ahoc_pkg::S_B0_CHK;
            end

            ahoc_pkg::S_B0_CHK:
            begin
                if (child_rdata != '0 && tail_reg < MAX_N)
                begin
                    fail_we     = 1'b1;
                    fail_waddr  = child_rdata;
                    queue_we    = 1'b1;
                    queue_waddr = tail_reg[NW-1:0];
                    queue_wdata = child_rdata;
                    tail_next   = tail_reg + 1'b1;
                end
                if (i_reg == LAST_LTR)
                begin
                    i_next     = '0;
                    state_next = ahoc_pkg::S_B_POP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ahoc_pkg::S_B0_RD;
                end
            end

            // Pop the next node, or finish the build
            ahoc_pkg::S_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    queue_re    = 1'b1;
                    queue_raddr = head_reg[NW-1:0];
                    head_next   = head_reg + 1'b1;
                    state_next  = ahoc_pkg::S_B_POPD;
                end
                else
                begin
                    state_next = ahoc_pkg::S_IDLE;
                end
            end

            ahoc_pkg::S_B_POPD:
            begin
                u_next     = queue_rdata;
                i_next     = '0;
                state_next = ahoc_pkg::S_B_KID_RD;
            end

            ahoc_pkg::S_B_KID_RD:
            begin
                child_re   = 1'b1;
                cm_node    = u_reg;
                state_next = ahoc_pkg::S_B_KID;
            end

            // Existing child: fetch the parent's link; else next letter, or pop after the last
            ahoc_pkg::S_B_KID:
            begin
                if (child_rdata != '0)
                begin
                    t_next     = child_rdata;
                    fail_re    = 1'b1;
                    fail_raddr = u_reg;
                    state_next = ahoc_pkg::S_B_FU;
                end
                else if (i_reg == LAST_LTR)
                begin
                    i_next     = '0;
                    state_next = ahoc_pkg::S_B_POP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ahoc_pkg::S_B_KID_RD;
                end
            end

            ahoc_pkg::S_B_FU:
            begin
                v_next         = fail_rdata;
                c_next         = i_reg;
                guard_next     = '0;
                ret_build_next = 1'b1;
                state_next     = ahoc_pkg::S_F_RD;
            end

            // Store the child's link and queue it
            ahoc_pkg::S_B_SET:
            begin
                fail_we    = 1'b1;
                fail_waddr = t_reg;
                fail_wdata = j_reg;
                if (tail_reg < MAX_N)
                begin
                    queue_we    = 1'b1;
                    queue_waddr = tail_reg[NW-1:0];
                    queue_wdata = t_reg;
                    tail_next   = tail_reg + 1'b1;
                end
                if (i_reg == LAST_LTR)
                begin
                    i_next     = '0;
                    state_next = ahoc_pkg::S_B_POP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ahoc_pkg::S_B_KID_RD;
                end
            end

            // Follow failure links until the letter has a child, the root is reached or the guard runs out
            ahoc_pkg::S_F_RD:
            begin
                child_re   = 1'b1;
                cm_node    = v_reg;
                cm_letter  = c_reg;
                state_next = ahoc_pkg::S_F_CHK;
            end

            ahoc_pkg::S_F_CHK:
            begin
                if (v_reg == '0 || child_rdata != '0 || guard_reg == MAX_N)
                begin
                    j_next     = child_rdata;
                    state_next = ret_build_reg ? ahoc_pkg::S_B_SET
                                               : ahoc_pkg::S_S_START;
                end
                else
                begin
                    fail_re    = 1'b1;
                    fail_raddr = v_reg;
                    state_next = ahoc_pkg::S_F_FL;
                end
            end

            ahoc_pkg::S_F_FL:
            begin
                v_next     = fail_rdata;
                guard_next = guard_reg + 1'b1;
                state_next = ahoc_pkg::S_F_RD;
            end

            ahoc_pkg::S_S_START:
            begin
                scan_cur_next = j_reg;
                t_next        = j_reg;
                guard_next    = '0;
                state_next    = ahoc_pkg::S_S_WALK;
            end

            // Walk the failure chain over unconsumed nodes
            ahoc_pkg::S_S_WALK:
            begin
                if (t_reg != '0 && guard_reg < MAX_N)
                begin
                    cons_re    = 1'b1;
                    cons_raddr = t_reg;
                    cnt_re     = 1'b1;
                    cnt_raddr  = t_reg;
                    fail_re    = 1'b1;
                    fail_raddr = t_reg;
                    state_next = ahoc_pkg::S_S_WCHK;
                end
                else
                begin
                    state_next = last_reg ? ahoc_pkg::S_EMIT : ahoc_pkg::S_IDLE;
                end
            end

            ahoc_pkg::S_S_WCHK:
            begin
                if (cons_rdata)
                begin
                    state_next = last_reg ? ahoc_pkg::S_EMIT : ahoc_pkg::S_IDLE;
                end
                else
                begin
                    total_next = sum[12] ? ahoc_pkg::COUNT_MAX : sum[11:0];
                    cons_we    = 1'b1;
                    cons_waddr = t_reg;
                    cons_wdata = 1'b1;
                    t_next     = fail_rdata;
                    guard_next = guard_reg + 1'b1;
                    state_next = ahoc_pkg::S_S_WALK;
                end
            end

            // Load the output register once it is free
            ahoc_pkg::S_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.match_count = total_reg;
                    out_next.overflow    = ovf_reg;
                    total_next           = '0;
                    scan_cur_next        = '0;
                    state_next           = ahoc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ahoc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ahoc_checker.sv -----
// ----------------------------------------------------------------------------
// ahoc_checker: port-level checks of the matcher
// Watches the top-level handshakes; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ahoc_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire ahoc_pkg::item_t   item,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire ahoc_pkg::result_t result
);

    // A stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // item_ready drops in the cycle after a transaction is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready right after accepting a transaction");

    // Neither ready nor a result during reset; the root sweep starts after it
    assert property (@(posedge clk)
        !rst_n |-> !item_ready && !result_valid)
        else $error("active during reset");

    // A result is loaded only from the emit step, never while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared while idle");

endmodule

bind aho_corasick_matcher ahoc_checker u_ahoc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Aho-Corasick dictionary matcher
// Loads random dictionaries, builds failure links and scans texts; every
// emitted count is checked against a behavioral trie kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int NODES = 4096;
    localparam int ABC   = 26;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    ahoc_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    ahoc_pkg::result_t result;

    aho_corasick_matcher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Behavioral trie state
    logic [11:0] trie_kid [NODES*ABC];
    logic [11:0] trie_fail [NODES];
    logic [11:0] trie_cnt [NODES];
    logic        trie_used [NODES];
    int          free_node;
    int          ins_node;
    int          scan_node;
    int          hit_total;
    logic        full_flag;
    logic        drop_pat;

    ahoc_pkg::item_t   pending_items [$];
    ahoc_pkg::result_t expected_counts [$];
    int      errors;
    int      results_seen;
    int      items_sent;
    int      scans_sent;
    int      overflow_seen;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic trie_clear();
        for (int i = 0; i < NODES*ABC; i++)
        begin
            trie_kid[i] = '0;
        end
        for (int i = 0; i < NODES; i++)
        begin
            trie_fail[i] = '0;
            trie_cnt[i]  = '0;
            trie_used[i] = 1'b0;
        end
        free_node = 1;
        ins_node  = 0;
        scan_node = 0;
        hit_total = 0;
        full_flag = 1'b0;
        drop_pat  = 1'b0;
    endtask

    function automatic int goto_next(int v, int c);
        int g;
        g = 0;
        while (v != 0 && trie_kid[v*ABC+c] == 0 && g < NODES)
        begin
            v = trie_fail[v];
            g++;
        end
        return trie_kid[v*ABC+c];
    endfunction

    task automatic trie_build();
        int order [$];
        int u;
        int t;
        for (int i = 0; i < ABC; i++)
        begin
            t = trie_kid[i];
            if (t != 0)
            begin
                trie_fail[t] = '0;
                order.push_back(t);
            end
        end
        while (order.size() > 0)
        begin
            u = order.pop_front();
            for (int i = 0; i < ABC; i++)
            begin
                t = trie_kid[u*ABC+i];
                if (t != 0)
                begin
                    trie_fail[t] = goto_next(trie_fail[u], i);
                    order.push_back(t);
                end
            end
        end
    endtask

    // Update the trie for one transaction and queue any expected count
    task automatic predict_match(ahoc_pkg::item_t it);
        int idx;
        int t;
        int g;
        ahoc_pkg::result_t r;
        case (it.op)
            ahoc_pkg::OP_CLEAR: trie_clear();
            ahoc_pkg::OP_INSERT:
            begin
                if (!drop_pat && it.letter < ABC)
                begin
                    idx = ins_node*ABC + it.letter;
                    if (trie_kid[idx] == 0)
                    begin
                        if (free_node < NODES)
                        begin
                            trie_kid[idx] = free_node[11:0];
                            free_node++;
                        end
                        else
                        begin
                            full_flag = 1'b1;
                            drop_pat  = 1'b1;
                        end
                    end
                    if (!drop_pat)
                        ins_node = trie_kid[idx];
                end
                if (it.last)
                begin
                    if (!drop_pat && trie_cnt[ins_node] < ahoc_pkg::COUNT_MAX)
                        trie_cnt[ins_node]++;
                    ins_node = 0;
                    drop_pat = 1'b0;
                end
            end
            ahoc_pkg::OP_BUILD: trie_build();
            default:
            begin
                scan_node = (it.letter < ABC) ? goto_next(scan_node, it.letter) : 0;
                t = scan_node;
                g = 0;
                while (t != 0 && !trie_used[t] && g < NODES)
                begin
                    hit_total += trie_cnt[t];
                    if (hit_total > ahoc_pkg::COUNT_MAX)
                        hit_total = ahoc_pkg::COUNT_MAX;
                    trie_used[t] = 1'b1;
                    t = trie_fail[t];
                    g++;
                end
                if (it.last)
                begin
                    r.match_count = hit_total[11:0];
                    r.overflow    = full_flag;
                    expected_counts.push_back(r);
                    hit_total = 0;
                    scan_node = 0;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic ahoc_pkg::item_t mk(logic [1:0] op, int letter, bit last);
        ahoc_pkg::item_t it;
        it.op     = op;
        it.letter = letter[4:0];
        it.last   = last;
        return it;
    endfunction

    task automatic add_word(int len, int span);
        for (int i = 0; i < len; i++)
        begin
            pending_items.push_back(mk(ahoc_pkg::OP_INSERT, $urandom_range(0, span-1),
                                       i == len-1));
        end
    endtask

    task automatic add_text(int len, int span);
        for (int i = 0; i < len; i++)
        begin
            pending_items.push_back(mk(ahoc_pkg::OP_SCAN, $urandom_range(0, span-1),
                                       i == len-1));
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Driver: present queued transactions with random gaps
    int  send_gap;
    bit  hold_off;
    bit  quiet_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            send_gap   <= 0;
        end
        else if (!item_valid || item_ready)
        begin
            if (item_valid)
                items_sent++;
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (hold_off && (expected_counts.size() > 0 || item_valid))
            begin
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                ahoc_pkg::item_t it;
                it = pending_items.pop_front();
                predict_match(it);
                if (it.op == ahoc_pkg::OP_SCAN)
                    scans_sent++;
                item_valid <= 1'b1;
                item       <= it;
                send_gap   <= quiet_phase ? 0 : gap_len();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, check each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                ahoc_pkg::result_t want;
                results_seen++;
                if (expected_counts.size() == 0)
                begin
                    report_mismatch("unexpected result", result.match_count, -1);
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (result.match_count !== want.match_count)
                        report_mismatch("match_count", result.match_count, want.match_count);
                    if (result.overflow !== want.overflow)
                        report_mismatch("overflow", result.overflow, want.overflow);
                    if (want.overflow)
                        overflow_seen++;
                end
            end
            result_ready <= quiet_phase ? 1'b1 : (gap_len() == 0);
        end
    end

    // Stimulus
    initial
    begin
        int n;
        errors        = 0;
        results_seen  = 0;
        items_sent    = 0;
        scans_sent    = 0;
        overflow_seen = 0;
        hold_off      = 1'b0;
        quiet_phase   = 1'b0;
        trie_clear();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: "he", "she", "az", empty pattern, odd letters
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 7, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 4, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 18, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 7, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 4, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 0, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 31, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 25, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 26, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_BUILD, 0, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 18, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 7, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 4, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 18, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 7, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 4, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_INSERT, 0, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 30, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 0, 0));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 25, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 31, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_CLEAR, 31, 1));
        pending_items.push_back(mk(ahoc_pkg::OP_SCAN, 0, 1));

        // Pause until every directed count has come back
        wait (pending_items.size() == 0);
        hold_off = 1'b1;
        wait (expected_counts.size() == 0 && !item_valid);
        hold_off = 1'b0;

        // Random dictionaries over mostly small alphabets so matches are frequent
        n = 0;
        while (n < 430)
        begin
            int span;
            int w;
            span = $urandom_range(2, 6);
            if ($urandom_range(0, 3) == 0)
                span = 26;
            pending_items.push_back(mk(ahoc_pkg::OP_CLEAR, $urandom, $urandom));
            n++;
            w = $urandom_range(1, 6);
            for (int k = 0; k < w; k++)
            begin
                int len;
                len = $urandom_range(1, 4);
                add_word(len, span);
                n += len;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                pending_items.push_back(mk(ahoc_pkg::OP_INSERT, $urandom_range(26, 31), 1));
                n++;
            end
            pending_items.push_back(mk(ahoc_pkg::OP_BUILD, $urandom, $urandom));
            n++;
            for (int k = 0; k < $urandom_range(1, 4); k++)
            begin
                int len;
                len = $urandom_range(1, 10);
                add_text(len, span);
                n += len;
            end
            // Insert after build and a stray letter, then one more text
            if ($urandom_range(0, 4) == 0)
            begin
                add_word(2, span);
                pending_items.push_back(mk(ahoc_pkg::OP_SCAN, $urandom_range(0, 31), 0));
                add_text(4, span);
                n += 7;
            end
            if (n > 200 && n < 260)
                quiet_phase = 1'b1;
            else
                quiet_phase = 1'b0;
            wait (pending_items.size() < 8);
        end

        wait (pending_items.size() == 0 && !item_valid);
        wait (expected_counts.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d transactions, %0d scan letters, %0d counts checked",
                 items_sent, scans_sent, results_seen);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Timeout
    initial
    begin
        #50ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ahoc_pkg.sv
rtl/core/ahoc_ram.sv
rtl/core/ahoc_ctrl.sv
rtl/core/aho_corasick_matcher.sv
rtl/core/ahoc_checker.sv
tb/testbench.sv
